### design/mvm_pkg.sv
// Shared types and constants for the matrix-vector multiply unit.
// No dependencies; imported by mvm_front, mvm_back and the top module.
package mvm_pkg;

	localparam int MAX_DIM     = 16;
	localparam int DIM_W       = $clog2(MAX_DIM);
	localparam int SIZE_W      = 5;
	localparam int DATA_W      = 32;
	localparam int PROD_W      = 2 * DATA_W;
	localparam int ACC_W       = PROD_W + 8;
	localparam int FRAC_W      = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		OP_WR_MAT  = 2'd0,
		OP_WR_VEC  = 2'd1,
		OP_PRODUCT = 2'd2,
		OP_UNUSED  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		K_MAT_WR,
		K_VEC_WR,
		K_PRODUCT
	} kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} back_state_t;

	typedef struct packed {
		op_t                op;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         out_row;
		logic signed [31:0] out_value;
		logic               last;
	} out_item_t;

	typedef struct packed {
		kind_t              kind;
		logic [DIM_W-1:0]   row;
		logic [DIM_W-1:0]   col;
		logic [DATA_W-1:0]  value;
	} q_item_t;

	// tag that travels with each MAC through the back-end pipeline
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             lastcol;
		logic             lastrow;
		logic [DIM_W-1:0] row;
	} mac_tag_t;

endpackage

### design/mvm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mvm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/mvm_front.sv
// Front end: takes command beats, classifies them and queues them for the back end.
// Depends on mvm_pkg.
module mvm_front
	import mvm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  in_item_t item,
	input  logic     q_pop,
	output logic     q_valid,
	output q_item_t  q_item
);

	q_item_t           fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;
	q_item_t           entry;

	assign busy    = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = fifo_q[rd_ptr_q];
	assign pop     = q_pop && q_valid;

	// the unused op is dropped here and never reaches the back end
	always_comb begin
		entry.row   = item.row;
		entry.col   = item.col;
		entry.value = item.value;
		entry.kind  = K_PRODUCT;
		push        = start && !busy;
		unique case (item.op)
			OP_WR_MAT:  entry.kind = K_MAT_WR;
			OP_WR_VEC:  entry.kind = K_VEC_WR;
			OP_PRODUCT: entry.kind = K_PRODUCT;
			OP_UNUSED:  push = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/mvm_back.sv
// Back end: applies entry writes and runs products as a row-major MAC sweep.
// Depends on mvm_pkg and mvm_ram.
module mvm_back
	import mvm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SIZE_W-1:0] size_in_use,
	input  logic              q_valid,
	input  q_item_t           q_item,
	output logic              q_pop,
	output logic              strobe,
	output out_item_t         result
);

	back_state_t          state_q, state_d;
	logic [SIZE_W-1:0]    n_q;
	logic [SIZE_W-1:0]    n_eff;
	logic [DIM_W-1:0]     nm1;
	logic [DIM_W-1:0]     r_q, c_q;
	logic                 load, issue, mat_we, vec_we;
	logic [DATA_W-1:0]    mat_rdata, vec_rdata;
	mac_tag_t             tag_s1, tag_s2, tag_s3, tag_d;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic                 strobe_q;
	out_item_t            result_q;

	function automatic logic [DATA_W-1:0] shift_sat(input logic signed [ACC_W-1:0] a);
		logic [ACC_W-FRAC_W-1:0] sh;
		logic [ACC_W-FRAC_W-DATA_W:0] top;
		sh  = a[ACC_W-1:FRAC_W];
		top = sh[ACC_W-FRAC_W-1:DATA_W-1];
		if ((&top) || !(|top)) begin
			return sh[DATA_W-1:0];
		end else if (sh[ACC_W-FRAC_W-1]) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

	// size zero acts as one, anything above MAX_DIM clamps
	always_comb begin
		if (size_in_use == '0) begin
			n_eff = SIZE_W'(1);
		end else if (size_in_use > SIZE_W'(MAX_DIM)) begin
			n_eff = SIZE_W'(MAX_DIM);
		end else begin
			n_eff = size_in_use;
		end
	end

	assign nm1 = DIM_W'(n_q - SIZE_W'(1));

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		load    = 1'b0;
		issue   = 1'b0;
		mat_we  = 1'b0;
		vec_we  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_item.kind)
						K_MAT_WR: mat_we = 1'b1;
						K_VEC_WR: vec_we = 1'b1;
						K_PRODUCT: begin
							load    = 1'b1;
							state_d = ST_RUN;
						end
						default: ;
					endcase
				end
			end
			ST_RUN: begin
				issue = 1'b1;
				if (r_q == nm1 && c_q == nm1) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	mvm_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_DIM * MAX_DIM)
	) u_mat_ram (
		.clk  (clk),
		.we   (mat_we),
		.waddr({q_item.row, q_item.col}),
		.wdata(q_item.value),
		.raddr({r_q, c_q}),
		.rdata(mat_rdata)
	);

	mvm_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_DIM)
	) u_vec_ram (
		.clk  (clk),
		.we   (vec_we),
		.waddr(q_item.col),
		.wdata(q_item.value),
		.raddr(c_q),
		.rdata(vec_rdata)
	);

	always_comb begin
		tag_d.valid   = issue;
		tag_d.first   = (c_q == '0);
		tag_d.lastcol = (c_q == nm1);
		tag_d.lastrow = (r_q == nm1);
		tag_d.row     = r_q;
	end

	assign prod_ext = {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			n_q      <= SIZE_W'(MAX_DIM);
			r_q      <= '0;
			c_q      <= '0;
			tag_s1   <= '0;
			tag_s2   <= '0;
			tag_s3   <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				n_q <= n_eff;
				r_q <= '0;
				c_q <= '0;
			end else if (issue) begin
				if (c_q == nm1) begin
					c_q <= '0;
					r_q <= r_q + 1'b1;
				end else begin
					c_q <= c_q + 1'b1;
				end
			end
			tag_s1   <= tag_d;
			tag_s2   <= tag_s1;
			tag_s3   <= tag_s2;
			strobe_q <= tag_s3.valid && tag_s3.lastcol;
		end
	end

	// datapath: RAM read -> multiply -> accumulate -> shift/saturate
	always_ff @(posedge clk) begin
		prod_s2 <= signed'(mat_rdata) * signed'(vec_rdata);
		if (tag_s2.valid) begin
			acc_q <= (tag_s2.first ? '0 : acc_q) + prod_ext;
		end
		if (tag_s3.valid && tag_s3.lastcol) begin
			result_q.out_row   <= tag_s3.row;
			result_q.out_value <= shift_sat(acc_q);
			result_q.last      <= tag_s3.lastrow;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

### design/matrix_vector_multiply_unit.sv
// Matrix-vector multiply unit, Q16.16, up to 16x16; uses mvm_pkg, mvm_front, mvm_back, mvm_ram.
// In the back end each write beat is applied as it is popped from the queue; a product with n rows in use
// runs n*n MACs, one MAC per cycle on the matrix RAM read port.
// Each row result strobes once its last column has been accumulated and saturated.
// busy rises only when the four-entry command queue is full; results cannot stall.
// Reset clears control and size_in_use (to 16); matrix and vector RAMs are not cleared.
module matrix_vector_multiply_unit
	import mvm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  in_item_t          item,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	output logic              strobe,
	output out_item_t         result
);

	logic [SIZE_W-1:0] size_q;
	logic              q_valid;
	logic              q_pop;
	q_item_t           q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(MAX_DIM);
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	mvm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.q_pop  (q_pop),
		.q_valid(q_valid),
		.q_item (q_item)
	);

	mvm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.size_in_use(size_q),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.strobe     (strobe),
		.result     (result)
	);

endmodule
